// ===== sv/acbc_pkg.sv =====
// Shared types and constants for the alarm clock button controller.
`default_nettype none

package acbc_pkg;

  localparam int NUM_ALARMS = 3;
  localparam logic [1:0] DEBOUNCE_TICKS = 2'd3;

  localparam logic [1:0] MODE_IDLE   = 2'd0;
  localparam logic [1:0] MODE_SCREEN = 2'd1;
  localparam logic [1:0] MODE_RING   = 2'd2;

  localparam logic [2:0] REG_ALARM_WORD_0      = 3'd0;
  localparam logic [2:0] REG_ALARM_WORD_1      = 3'd1;
  localparam logic [2:0] REG_ALARM_WORD_2      = 3'd2;
  localparam logic [2:0] REG_SCREEN_TIMEOUT_MS = 3'd3;
  localparam logic [2:0] REG_RING_TIMEOUT_MS   = 3'd4;
  localparam logic [2:0] REG_CHECK_INTERVAL_MS = 3'd5;
  localparam logic [2:0] REG_DIM_LEVEL         = 3'd6;
  localparam logic [2:0] REG_BRIGHT_LEVEL      = 3'd7;

  localparam logic [23:0] SCREEN_TIMEOUT_RESET = 24'd5000;
  localparam logic [23:0] RING_TIMEOUT_RESET   = 24'd90000;
  localparam logic [23:0] CHECK_INTERVAL_RESET = 24'd1000;
  localparam logic [7:0]  DIM_LEVEL_RESET      = 8'd1;
  localparam logic [7:0]  BRIGHT_LEVEL_RESET   = 8'd60;

  typedef struct packed {
    logic        button_level;
    logic [31:0] now_ms;
    logic [2:0]  weekday;
    logic [4:0]  hour;
    logic [5:0]  minute;
  } in_t;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] backlight_level;
    logic       backlight_write;
    logic       press_event;
  } out_t;

  typedef struct packed {
    logic [NUM_ALARMS-1:0][18:0] alarm_word;
    logic [23:0]                 screen_timeout_ms;
    logic [23:0]                 ring_timeout_ms;
    logic [23:0]                 check_interval_ms;
    logic [7:0]                  dim_level;
    logic [7:0]                  bright_level;
  } cfg_t;

endpackage

`default_nettype wire

// ===== sv/alarm_clock_button_controller.sv =====
// Top level of the alarm clock button controller: input and result registers around the core.
`default_nettype none

// One tick per transaction, one result per tick. A tick is taken into an input
// register, worked combinationally through the core and written to the result
// register, and a new tick is accepted every cycle while the result side keeps
// up. Configuration writes are always ready and take effect on the next cycle;
// write them only while no tick is in flight.
module alarm_clock_button_controller (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire acbc_pkg::in_t  in_data,
  output logic                out_valid,
  input  wire logic           out_stall,
  output acbc_pkg::out_t      out_data,
  input  wire logic           cfg_valid,
  output logic                cfg_ready,
  input  wire logic [2:0]     cfg_index,
  input  wire logic [23:0]    cfg_data
);
  import acbc_pkg::*;

  cfg_t cfg;
  in_t  in_q;
  logic in_q_valid;
  out_t result;
  logic advance;
  logic accept;

  acbc_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  acbc_core u_core (
    .clk    (clk),
    .rst    (rst),
    .fire   (advance),
    .item   (in_q),
    .cfg    (cfg),
    .result (result)
  );

  assign advance  = in_q_valid && (!out_valid || !out_stall);
  assign in_stall = in_q_valid && !advance;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (accept) begin
      in_q_valid <= 1'b1;
    end else if (advance) begin
      in_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_q <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= result;
    end
  end

  a_advance_fills_output: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("worked transaction did not reach the result register");

  a_stall_needs_item: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> in_q_valid)
    else $error("input stalled with an empty input register");

  a_blocked_item_held: assert property (@(posedge clk) disable iff (rst)
    in_q_valid && !advance |=> in_q_valid)
    else $error("blocked transaction lost from the input register");

endmodule

`default_nettype wire

// ===== sv/acbc_cfg_regs.sv =====
// Configuration register file for the alarm clock button controller.
`default_nettype none

module acbc_cfg_regs (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [23:0]        cfg_data,
  output acbc_pkg::cfg_t          cfg
);
  import acbc_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.alarm_word        <= '0;
      cfg.screen_timeout_ms <= SCREEN_TIMEOUT_RESET;
      cfg.ring_timeout_ms   <= RING_TIMEOUT_RESET;
      cfg.check_interval_ms <= CHECK_INTERVAL_RESET;
      cfg.dim_level         <= DIM_LEVEL_RESET;
      cfg.bright_level      <= BRIGHT_LEVEL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ALARM_WORD_0:      cfg.alarm_word[0] <= cfg_data[18:0];
        REG_ALARM_WORD_1:      cfg.alarm_word[1] <= cfg_data[18:0];
        REG_ALARM_WORD_2:      cfg.alarm_word[2] <= cfg_data[18:0];
        REG_SCREEN_TIMEOUT_MS: cfg.screen_timeout_ms <= cfg_data;
        REG_RING_TIMEOUT_MS:   cfg.ring_timeout_ms <= cfg_data;
        REG_CHECK_INTERVAL_MS: cfg.check_interval_ms <= cfg_data;
        REG_DIM_LEVEL:         cfg.dim_level <= cfg_data[7:0];
        REG_BRIGHT_LEVEL:      cfg.bright_level <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== sv/acbc_core.sv =====
// Debounce, alarm match, mode state machine and backlight choice for one tick.
`default_nettype none

module acbc_core (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           fire,
  input  wire acbc_pkg::in_t  item,
  input  wire acbc_pkg::cfg_t cfg,
  output acbc_pkg::out_t      result
);
  import acbc_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCREEN = 3'b010,
    ST_RING   = 3'b100
  } state_t;

  state_t      state, state_next;
  logic        alarm_pending, alarm_pending_next;
  logic [1:0]  stable_ticks, stable_ticks_next;
  logic        last_level, last_level_next;
  logic        press_handled, press_handled_next;
  logic [5:0]  last_checked_minute, last_checked_minute_next;
  logic [31:0] last_check_time, last_check_time_next;
  logic [31:0] screen_start_time, screen_start_time_next;
  logic [31:0] ring_start_time, ring_start_time_next;
  logic [7:0]  last_written_level, last_written_level_next;

  logic                  press;
  logic [31:0]           check_elapsed, screen_elapsed, ring_elapsed;
  logic                  check_due, screen_expired, ring_expired;
  logic [NUM_ALARMS-1:0] match;
  logic [6:0]            day_mask;
  logic [7:0]            level;

  assign check_elapsed  = item.now_ms - last_check_time;
  assign screen_elapsed = item.now_ms - screen_start_time;
  assign ring_elapsed   = item.now_ms - ring_start_time;
  assign check_due      = check_elapsed > {8'd0, cfg.check_interval_ms};
  assign screen_expired = screen_elapsed > {8'd0, cfg.screen_timeout_ms};
  assign ring_expired   = ring_elapsed > {8'd0, cfg.ring_timeout_ms};

  always_comb begin
    for (int i = 0; i < NUM_ALARMS; i++) begin
      day_mask = cfg.alarm_word[i][7:1];
      match[i] = cfg.alarm_word[i][0]
                 && (item.weekday != 3'd7) && day_mask[item.weekday]
                 && (cfg.alarm_word[i][12:8] == item.hour)
                 && (cfg.alarm_word[i][18:13] == item.minute);
    end
  end

  always_comb begin
    stable_ticks_next        = stable_ticks;
    last_level_next          = last_level;
    press_handled_next       = press_handled;
    alarm_pending_next       = alarm_pending;
    last_checked_minute_next = last_checked_minute;
    last_check_time_next     = last_check_time;
    screen_start_time_next   = screen_start_time;
    ring_start_time_next     = ring_start_time;
    state_next               = state;

    if (item.button_level == last_level) begin
      if (stable_ticks < DEBOUNCE_TICKS) begin
        stable_ticks_next = stable_ticks + 2'd1;
      end
    end else begin
      stable_ticks_next  = 2'd0;
      press_handled_next = 1'b0;
      last_level_next    = item.button_level;
    end
    press = (stable_ticks_next == DEBOUNCE_TICKS) && !item.button_level
            && !press_handled_next;
    if (press) begin
      press_handled_next = 1'b1;
    end

    if (check_due) begin
      last_check_time_next = item.now_ms;
      if (item.minute != last_checked_minute) begin
        last_checked_minute_next = item.minute;
        if (|match) begin
          alarm_pending_next = 1'b1;
        end
      end
    end

    unique case (state)
      ST_SCREEN: begin
        level = cfg.bright_level;
        if (screen_expired) begin
          state_next = ST_IDLE;
        end else if (alarm_pending_next) begin
          state_next           = ST_RING;
          ring_start_time_next = item.now_ms;
        end
      end
      ST_RING: begin
        level = cfg.bright_level;
        if (ring_expired || press) begin
          state_next         = ST_IDLE;
          alarm_pending_next = 1'b0;
        end
      end
      default: begin
        level      = cfg.dim_level;
        state_next = ST_IDLE;
        if (press) begin
          state_next             = ST_SCREEN;
          screen_start_time_next = item.now_ms;
        end else if (alarm_pending_next) begin
          state_next           = ST_RING;
          ring_start_time_next = item.now_ms;
        end
      end
    endcase

    last_written_level_next = level;

    unique case (state_next)
      ST_SCREEN: result.mode = MODE_SCREEN;
      ST_RING:   result.mode = MODE_RING;
      default:   result.mode = MODE_IDLE;
    endcase
    result.backlight_level = level;
    result.backlight_write = level != last_written_level;
    result.press_event     = press;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state               <= ST_IDLE;
      alarm_pending       <= 1'b0;
      stable_ticks        <= 2'd0;
      last_level          <= 1'b1;
      press_handled       <= 1'b0;
      last_checked_minute <= 6'd63;
      last_check_time     <= '0;
      screen_start_time   <= '0;
      ring_start_time     <= '0;
      last_written_level  <= '0;
    end else if (fire) begin
      state               <= state_next;
      alarm_pending       <= alarm_pending_next;
      stable_ticks        <= stable_ticks_next;
      last_level          <= last_level_next;
      press_handled       <= press_handled_next;
      last_checked_minute <= last_checked_minute_next;
      last_check_time     <= last_check_time_next;
      screen_start_time   <= screen_start_time_next;
      ring_start_time     <= ring_start_time_next;
      last_written_level  <= last_written_level_next;
    end
  end

  a_press_marks_handled: assert property (@(posedge clk) disable iff (rst)
    fire && result.press_event |=> press_handled)
    else $error("press fired but was not marked handled");

  a_written_level_tracks: assert property (@(posedge clk) disable iff (rst)
    fire && result.backlight_write |=> last_written_level == $past(result.backlight_level))
    else $error("written backlight level not recorded");

  a_press_stops_ring: assert property (@(posedge clk) disable iff (rst)
    fire && state == ST_RING && result.press_event |=> state == ST_IDLE && !alarm_pending)
    else $error("press while ringing did not return to idle");

endmodule

`default_nettype wire

// ===== verif/tb_alarm_clock_button_controller.sv =====
// Self-checking testbench for the alarm clock button controller.
`default_nettype none

module tb_alarm_clock_button_controller;
  timeunit 1ns;
  timeprecision 1ps;
  import acbc_pkg::*;

  localparam int IDLE_LIMIT = 5000;
  localparam int SETTLE_CYCLES = 6;
  localparam int LONG_HOLD = 80;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_t         in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_t        out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = REG_ALARM_WORD_0;
  logic [23:0] cfg_data = '0;

  alarm_clock_button_controller uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Controller registers as last written
  logic [18:0] alarm_cfg [NUM_ALARMS] = '{default: '0};
  logic [23:0] screen_limit = SCREEN_TIMEOUT_RESET;
  logic [23:0] ring_limit   = RING_TIMEOUT_RESET;
  logic [23:0] check_gap    = CHECK_INTERVAL_RESET;
  logic [7:0]  dim_cfg      = DIM_LEVEL_RESET;
  logic [7:0]  bright_cfg   = BRIGHT_LEVEL_RESET;

  // Controller state
  logic [1:0]  ctl_mode      = MODE_IDLE;
  logic        alarm_latched = 1'b0;
  logic [1:0]  debounce_cnt  = '0;
  logic        prev_level    = 1'b1;
  logic        press_taken   = 1'b0;
  logic [5:0]  seen_minute   = 6'd63;
  logic [31:0] check_stamp   = '0;
  logic [31:0] screen_stamp  = '0;
  logic [31:0] ring_stamp    = '0;
  logic [7:0]  written_level = '0;

  out_t expected_q [$];

  // Stimulus state
  logic        tx_idle = 1'b1;
  logic        rx_idle = 1'b1;
  int          rx_hold = 0;
  logic        btn_level = 1'b1;
  int          btn_run = 0;
  logic [31:0] clock_ms = '0;
  int          step_max = 8;

  int mismatches = 0;
  int n_ticks = 0;
  int n_results = 0;
  int n_writes = 0;
  int n_presses = 0;
  int n_ringing = 0;
  int n_screen = 0;
  int idle_cycles = 0;
  out_t want;

  function automatic out_t step_controller(in_t t);
    out_t        r;
    logic        fired;
    logic [7:0]  lvl;
    logic [31:0] gap;
    logic [18:0] w;
    fired = 1'b0;
    if (t.button_level == prev_level) begin
      if (debounce_cnt < DEBOUNCE_TICKS) debounce_cnt++;
    end else begin
      debounce_cnt = '0;
      press_taken = 1'b0;
      prev_level = t.button_level;
    end
    if (debounce_cnt == DEBOUNCE_TICKS && !t.button_level && !press_taken) begin
      fired = 1'b1;
      press_taken = 1'b1;
    end
    gap = t.now_ms - check_stamp;
    if (gap > {8'd0, check_gap}) begin
      if (t.minute != seen_minute) begin
        seen_minute = t.minute;
        for (int i = 0; i < NUM_ALARMS; i++) begin
          w = alarm_cfg[i];
          if (w[0] && t.weekday <= 3'd6 && w[5'(t.weekday) + 5'd1] &&
              w[12:8] == t.hour && w[18:13] == t.minute) alarm_latched = 1'b1;
        end
      end
      check_stamp = t.now_ms;
    end
    case (ctl_mode)
      MODE_SCREEN: begin
        lvl = bright_cfg;
        gap = t.now_ms - screen_stamp;
        if (gap > {8'd0, screen_limit}) begin
          ctl_mode = MODE_IDLE;
        end else if (alarm_latched) begin
          ctl_mode = MODE_RING;
          ring_stamp = t.now_ms;
        end
      end
      MODE_RING: begin
        lvl = bright_cfg;
        gap = t.now_ms - ring_stamp;
        if (gap > {8'd0, ring_limit} || fired) begin
          ctl_mode = MODE_IDLE;
          alarm_latched = 1'b0;
        end
      end
      default: begin
        lvl = dim_cfg;
        ctl_mode = MODE_IDLE;
        if (fired) begin
          ctl_mode = MODE_SCREEN;
          screen_stamp = t.now_ms;
        end else if (alarm_latched) begin
          ctl_mode = MODE_RING;
          ring_stamp = t.now_ms;
        end
      end
    endcase
    r.mode = ctl_mode;
    r.backlight_level = lvl;
    r.backlight_write = (lvl != written_level);
    r.press_event = fired;
    if (r.backlight_write) written_level = lvl;
    return r;
  endfunction

  function automatic void note_failure(string msg);
    mismatches++;
    if (mismatches <= 10) $display("%s", msg);
  endfunction

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      n_results++;
      if (expected_q.size() == 0) begin
        note_failure($sformatf("unexpected result: mode %0d level %0d write %0b press %0b",
                               out_data.mode, out_data.backlight_level,
                               out_data.backlight_write, out_data.press_event));
      end else begin
        want = expected_q.pop_front();
        if (out_data.mode !== want.mode || out_data.backlight_level !== want.backlight_level ||
            out_data.backlight_write !== want.backlight_write ||
            out_data.press_event !== want.press_event)
          note_failure($sformatf({"result %0d: expected mode %0d level %0d write %0b press %0b,",
                                  " got mode %0d level %0d write %0b press %0b"},
                                 n_results, want.mode, want.backlight_level,
                                 want.backlight_write, want.press_event, out_data.mode,
                                 out_data.backlight_level, out_data.backlight_write,
                                 out_data.press_event));
      end
    end
    if (!rst && in_valid && !in_stall) begin
      want = step_controller(in_data);
      expected_q.push_back(want);
      n_ticks++;
      if (want.press_event) n_presses++;
      if (want.mode == MODE_RING) n_ringing++;
      if (want.mode == MODE_SCREEN) n_screen++;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_alarm_clock_button_controller NOT OK");
      $finish;
    end
  end

  initial begin : result_sink
    int n;
    @(negedge clk);
    forever begin
      if (rx_hold != 0) begin
        n = rx_hold;
        rx_hold = 0;
      end else begin
        n = rx_idle ? $urandom_range(0, 3) : 0;
      end
      if (n != 0) begin
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
      @(negedge clk);
    end
  end

  task automatic send_tick(input in_t t);
    int gap;
    gap = tx_idle ? $urandom_range(0, 3) : 0;
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= t;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [23:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_ALARM_WORD_0, REG_ALARM_WORD_1, REG_ALARM_WORD_2: alarm_cfg[idx[1:0]] = val[18:0];
      REG_SCREEN_TIMEOUT_MS: screen_limit = val;
      REG_RING_TIMEOUT_MS:   ring_limit = val;
      REG_CHECK_INTERVAL_MS: check_gap = val;
      REG_DIM_LEVEL:         dim_cfg = val[7:0];
      REG_BRIGHT_LEVEL:      bright_cfg = val[7:0];
      default: ;
    endcase
    n_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic apply_setting(input logic [18:0] w0, input logic [18:0] w1,
                               input logic [18:0] w2, input logic [23:0] scr,
                               input logic [23:0] ring, input logic [23:0] chk,
                               input logic [7:0] dim, input logic [7:0] bright);
    write_reg(REG_ALARM_WORD_0, {5'($urandom), w0});
    write_reg(REG_ALARM_WORD_1, {5'($urandom), w1});
    write_reg(REG_ALARM_WORD_2, {5'($urandom), w2});
    write_reg(REG_SCREEN_TIMEOUT_MS, scr);
    write_reg(REG_RING_TIMEOUT_MS, ring);
    write_reg(REG_CHECK_INTERVAL_MS, chk);
    write_reg(REG_DIM_LEVEL, {16'($urandom), dim});
    write_reg(REG_BRIGHT_LEVEL, {16'($urandom), bright});
  endtask

  function automatic logic [18:0] rand_alarm();
    logic [5:0] mn;
    logic [4:0] hr;
    mn = ($urandom_range(0, 7) == 0) ? 6'($urandom) : 6'($urandom_range(0, 59));
    hr = ($urandom_range(0, 7) == 0) ? 5'($urandom) : 5'($urandom_range(0, 23));
    return {mn, hr, 7'($urandom), 1'($urandom_range(0, 3) != 0)};
  endfunction

  function automatic in_t tick_of(int lvl, logic [31:0] now, int wd, int hr, int mn);
    return '{1'(lvl), now, 3'(wd), 5'(hr), 6'(mn)};
  endfunction

  function automatic in_t next_tick();
    in_t         t;
    logic [18:0] w;
    if ($urandom_range(0, 9) == 0) begin
      t.button_level = 1'($urandom);
      t.now_ms = $urandom;
      t.weekday = 3'($urandom);
      t.hour = 5'($urandom);
      t.minute = 6'($urandom);
      return t;
    end
    if (btn_run == 0) begin
      btn_level = ~btn_level;
      btn_run = $urandom_range(1, 6);
    end
    btn_run--;
    clock_ms += ($urandom_range(0, 49) == 0) ? $urandom : $urandom_range(0, step_max);
    t.button_level = btn_level;
    t.now_ms = clock_ms;
    t.weekday = 3'($urandom_range(0, 6));
    if ($urandom_range(0, 1) == 0) begin
      w = alarm_cfg[2'($urandom_range(0, NUM_ALARMS - 1))];
      t.hour = w[12:8];
      t.minute = w[18:13];
    end else begin
      t.hour = 5'($urandom_range(0, 23));
      t.minute = 6'($urandom_range(0, 59));
    end
    return t;
  endfunction

  task automatic run_ticks(input int n);
    repeat (n) send_tick(next_tick());
  endtask

  task automatic test_directed();
    write_reg(REG_ALARM_WORD_0, {5'd0, 6'd30, 5'd7, 7'b0001000, 1'b1});
    write_reg(REG_ALARM_WORD_1, {5'd0, 6'd59, 5'd23, 7'b1000000, 1'b1});
    write_reg(REG_ALARM_WORD_2, {5'd0, 19'h7FFFF});
    send_tick(tick_of(1, 0, 0, 0, 0));
    send_tick(tick_of(1, 1000, 0, 0, 0));
    send_tick(tick_of(1, 1001, 3, 7, 63));
    send_tick(tick_of(0, 2002, 7, 7, 30));
    send_tick(tick_of(0, 2010, 3, 7, 30));
    send_tick(tick_of(0, 2020, 3, 7, 30));
    send_tick(tick_of(0, 2030, 3, 7, 30));
    send_tick(tick_of(0, 2040, 3, 7, 30));
    send_tick(tick_of(1, 2050, 3, 7, 30));
    send_tick(tick_of(1, 7030, 3, 7, 31));
    send_tick(tick_of(1, 7031, 3, 7, 31));
    send_tick(tick_of(1, 9000, 3, 7, 30));
    send_tick(tick_of(1, 99000, 3, 7, 30));
    send_tick(tick_of(1, 99001, 3, 7, 30));
    send_tick(tick_of(1, 100500, 6, 23, 59));
    send_tick(tick_of(0, 100510, 6, 23, 59));
    send_tick(tick_of(0, 100520, 6, 23, 59));
    send_tick(tick_of(0, 100530, 6, 23, 59));
    send_tick(tick_of(0, 100540, 6, 23, 59));
    send_tick(tick_of(1, 32'hFFFF_FFFF, 5, 31, 60));
    send_tick(tick_of(0, 5, 0, 31, 63));
    send_tick(tick_of(0, 15, 0, 31, 63));
    send_tick(tick_of(0, 25, 0, 31, 63));
    send_tick(tick_of(0, 1100, 0, 31, 63));
    send_tick(tick_of(1, 1110, 0, 31, 63));
    drain();
  endtask

  task automatic test_config_extremes();
    apply_setting(rand_alarm(), rand_alarm(), rand_alarm(), 24'd20, 24'd60, 24'd5,
                  8'd0, 8'd255);
    step_max = 8;
    run_ticks(150);
    drain();
    apply_setting(rand_alarm(), rand_alarm(), rand_alarm(), 24'd0, 24'd0, 24'd0,
                  8'd255, 8'd0);
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    step_max = 3;
    run_ticks(150);
    drain();
    apply_setting(rand_alarm(), rand_alarm(), rand_alarm(), 24'hFFFFFF, 24'hFFFFFF,
                  24'hFFFFFF, 8'($urandom), 8'($urandom));
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    step_max = 24'hFFFFFF / 2;
    run_ticks(150);
    drain();
  endtask

  task automatic test_backpressure();
    apply_setting(rand_alarm(), rand_alarm(), rand_alarm(), 24'd40, 24'd120, 24'd10,
                  8'($urandom), 8'($urandom));
    step_max = 12;
    tx_idle = 1'b0;
    rx_hold = LONG_HOLD;
    run_ticks(75);
    rx_hold = LONG_HOLD;
    run_ticks(75);
    tx_idle = 1'b1;
    drain();
  endtask

  task automatic test_drain_pause();
    apply_setting(rand_alarm(), rand_alarm(), rand_alarm(), 24'($urandom_range(0, 300)),
                  24'($urandom_range(0, 600)), 24'($urandom_range(0, 60)),
                  8'($urandom), 8'($urandom));
    step_max = 50;
    run_ticks(75);
    drain();
    run_ticks(75);
    drain();
  endtask

  task automatic test_random_settings();
    repeat (3) begin
      apply_setting(rand_alarm(), rand_alarm(), rand_alarm(), 24'($urandom_range(0, 300)),
                    24'($urandom_range(0, 600)), 24'($urandom_range(0, 60)),
                    8'($urandom), 8'($urandom));
      tx_idle = 1'($urandom);
      rx_idle = 1'($urandom);
      step_max = $urandom_range(5, 60);
      run_ticks(150);
      drain();
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_config_extremes();
    test_backpressure();
    test_drain_pause();
    test_random_settings();
    $display("Covered %0d ticks across %0d register writes: %0d presses, %0d screen-on ticks,",
             n_ticks, n_writes, n_presses, n_screen);
    $display("%0d ringing ticks; %0d results checked, %0d mismatches.",
             n_ringing, n_results, mismatches);
    if (mismatches == 0)
      $display("tb_alarm_clock_button_controller OK");
    else
      $display("tb_alarm_clock_button_controller NOT OK");
    $finish;
  end

endmodule

`default_nettype wire
